>>> src/mbt_pkg.sv
package mbt_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int SIG_DEPTH_DEF  = 1024;
  localparam int NUM_W          = 9;
  localparam int W_IDX_W        = 4;
  localparam int TGT_W          = 17;
  localparam int PRED_W         = 17;
  localparam int IN_DATA_W      = 120;
  localparam int OUT_DATA_W     = 24;

  typedef enum logic [1:0] {
    OP_TRAIN   = 2'd0,
    OP_PREDICT = 2'd1,
    OP_LOAD    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_NOP, K_MUL, K_ADD, K_SIGI, K_SIGR
  } kind_t;

  typedef enum logic [4:0] {
    S_ZERO, S_X0, S_X1, S_S0, S_S1, S_P, S_ONEMP, S_ONEMS0, S_ONEMS1, S_ERR,
    S_T0, S_T1, S_DELTA, S_HD0, S_HD1, S_LD0, S_LD1, S_LDO, S_LR,
    S_W0, S_W1, S_W2, S_W3, S_W4, S_W5, S_W6, S_W7, S_W8
  } src_t;

  typedef enum logic [4:0] {
    D_T0, D_T1, D_S0, D_S1, D_P, D_DELTA, D_HD0, D_HD1, D_LD0, D_LD1, D_LDO,
    D_W0, D_W1, D_W2, D_W3, D_W4, D_W5, D_W6, D_W7, D_W8
  } dst_t;

  typedef struct packed {
    kind_t kind;
    src_t  a;
    src_t  b;
    src_t  c;
    dst_t  dst;
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic capture;
    logic out_load;
    logic out_zero;
  } dp_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

>>> src/mbt_sig_rom.sv
module mbt_sig_rom import mbt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DEPTH     = SIG_DEPTH_DEF,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic [AW-1:0]        addr,
  output logic [FRAC_BITS:0]   q_r
);

  typedef logic [FRAC_BITS:0] tab_t [DEPTH];

  function automatic tab_t build();
    tab_t        t;
    logic [63:0] q30, h, term, base, e, s30, sp, sn, one;
    int          half, shift;
    q30   = 64'd1 << 30;
    h     = (64'd16 << 30) / DEPTH;
    term  = q30;
    base  = q30;
    half  = DEPTH / 2;
    shift = 30 - FRAC_BITS;
    one   = 64'd1 << FRAC_BITS;
    e     = q30;
    for (int n = 1; n <= 10; n++) begin
      term = udiv64((term * h) >> 30, 64'(n));
      if (n % 2 == 1) base = base - term;
      else base = base + term;
    end
    for (int m = 0; m <= half + 1; m++) begin
      s30 = udiv64(64'd1 << 60, q30 + e);
      sp  = (s30 + (64'd1 << (shift - 1))) >> shift;
      sn  = one - sp;
      if (half + m < DEPTH) t[half + m] = sp[FRAC_BITS:0];
      if (half - m >= 0) t[half - m] = sn[FRAC_BITS:0];
      e = (e * base) >> 30;
    end
    return t;
  endfunction

  localparam tab_t TAB = build();

  always_ff @(posedge clk) begin
    q_r <= TAB[addr];
  end

endmodule

>>> src/mbt_dp.sv
module mbt_dp import mbt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DEPTH     = SIG_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_ctl_t                ctl,
  input  logic [IN_DATA_W-1:0]   in_data,
  input  logic                   cfg_we,
  input  logic [TGT_W-1:0]       cfg_wdata,
  output logic [PRED_W-1:0]      pred_r
);

  localparam int AW = $clog2(DEPTH);
  localparam logic signed [31:0] ONE_FX = 32'sh1 <<< FRAC_BITS;
  localparam logic signed [33:0] EIGHT  = 34'sh8 <<< FRAC_BITS;
  localparam logic [TGT_W-1:0]   LR_RST = TGT_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [47:0]        LAST   = 48'(DEPTH - 1);

  logic signed [31:0] w_r [NUM_W];
  logic signed [31:0] x0_r, x1_r, s0_r, s1_r, p_r, t0_r, t1_r;
  logic signed [31:0] delta_r, hd0_r, hd1_r, ld0_r, ld1_r, ldo_r;
  logic [TGT_W-1:0]   tgt_r, lr_r;

  logic signed [31:0] opa, opb, opc, res;
  logic signed [63:0] prod;
  logic signed [63:0] sum;
  logic [47:0]        scaled;
  logic signed [33:0] zoff;
  logic [AW-1:0]      rom_addr;
  logic [FRAC_BITS:0] rom_q;

  function automatic logic signed [31:0] pick(input src_t s);
    logic signed [31:0] v;
    case (s)
      S_ZERO:   v = '0;
      S_X0:     v = x0_r;
      S_X1:     v = x1_r;
      S_S0:     v = s0_r;
      S_S1:     v = s1_r;
      S_P:      v = p_r;
      S_ONEMP:  v = ONE_FX - p_r;
      S_ONEMS0: v = ONE_FX - s0_r;
      S_ONEMS1: v = ONE_FX - s1_r;
      S_ERR:    v = $signed({{(32-TGT_W){1'b0}}, tgt_r}) - p_r;
      S_T0:     v = t0_r;
      S_T1:     v = t1_r;
      S_DELTA:  v = delta_r;
      S_HD0:    v = hd0_r;
      S_HD1:    v = hd1_r;
      S_LD0:    v = ld0_r;
      S_LD1:    v = ld1_r;
      S_LDO:    v = ldo_r;
      S_LR:     v = $signed({{(32-TGT_W){1'b0}}, lr_r});
      S_W0:     v = w_r[0];
      S_W1:     v = w_r[1];
      S_W2:     v = w_r[2];
      S_W3:     v = w_r[3];
      S_W4:     v = w_r[4];
      S_W5:     v = w_r[5];
      S_W6:     v = w_r[6];
      S_W7:     v = w_r[7];
      S_W8:     v = w_r[8];
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa  = pick(ctl.cmd.a);
    opb  = pick(ctl.cmd.b);
    opc  = pick(ctl.cmd.c);
    prod = opa * opb;
    sum  = 64'(opa) + 64'(opb) + 64'(opc);
    case (ctl.cmd.kind)
      K_MUL:   res = sat32(prod >>> FRAC_BITS);
      K_ADD:   res = sat32(sum);
      K_SIGR:  res = $signed({{(31-FRAC_BITS){1'b0}}, rom_q});
      default: res = '0;
    endcase
    // sigmoid index: floor((z + 8) * DEPTH / 16), clamped
    zoff   = 34'(opa) + EIGHT;
    scaled = (48'(zoff[32:0]) * 48'(DEPTH)) >> (FRAC_BITS + 4);
    if (zoff[33]) rom_addr = '0;
    else if (scaled > LAST) rom_addr = LAST[AW-1:0];
    else rom_addr = scaled[AW-1:0];
  end

  mbt_sig_rom #(.FRAC_BITS(FRAC_BITS), .DEPTH(DEPTH)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q_r  (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_W; i++) w_r[i] <= '0;
      lr_r <= LR_RST;
    end else begin
      if (cfg_we) lr_r <= cfg_wdata;
      if (ctl.capture && op_t'(in_data[1:0]) == OP_LOAD &&
          in_data[86:83] < W_IDX_W'(NUM_W))
        w_r[in_data[86:83]] <= $signed(in_data[118:87]);
      if (ctl.cmd.kind == K_MUL || ctl.cmd.kind == K_ADD || ctl.cmd.kind == K_SIGR) begin
        case (ctl.cmd.dst)
          D_W0: w_r[0] <= res;
          D_W1: w_r[1] <= res;
          D_W2: w_r[2] <= res;
          D_W3: w_r[3] <= res;
          D_W4: w_r[4] <= res;
          D_W5: w_r[5] <= res;
          D_W6: w_r[6] <= res;
          D_W7: w_r[7] <= res;
          D_W8: w_r[8] <= res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      x0_r  <= $signed(in_data[33:2]);
      x1_r  <= $signed(in_data[65:34]);
      tgt_r <= in_data[82:66];
    end
    if (ctl.cmd.kind == K_MUL || ctl.cmd.kind == K_ADD || ctl.cmd.kind == K_SIGR) begin
      case (ctl.cmd.dst)
        D_T0:    t0_r <= res;
        D_T1:    t1_r <= res;
        D_S0:    s0_r <= res;
        D_S1:    s1_r <= res;
        D_P:     p_r <= res;
        D_DELTA: delta_r <= res;
        D_HD0:   hd0_r <= res;
        D_HD1:   hd1_r <= res;
        D_LD0:   ld0_r <= res;
        D_LD1:   ld1_r <= res;
        D_LDO:   ldo_r <= res;
        default: ;
      endcase
    end
    if (ctl.out_load) pred_r <= ctl.out_zero ? '0 : p_r[PRED_W-1:0];
  end

endmodule

>>> src/mbt_ctrl.sv
module mbt_ctrl import mbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic [1:0] in_op,
  output logic     in_tready,
  output logic     out_tvalid_r,
  input  logic     out_tready,
  output dp_ctl_t  ctl
);

  localparam logic [5:0] LAST_PRED  = 6'd14;
  localparam logic [5:0] LAST_TRAIN = 6'd40;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t     state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  op_t        op_r, op_nxt;
  logic       zero_r, zero_nxt;
  logic       outv_nxt;
  logic       accept, deliver;

  function automatic cmd_t mk(input kind_t k, input src_t a, input src_t b,
                              input src_t c, input dst_t d);
    cmd_t r;
    r.kind = k; r.a = a; r.b = b; r.c = c; r.dst = d;
    return r;
  endfunction

  // microcode: forward pass, then deltas and weight updates
  function automatic cmd_t prog(input logic [5:0] pc);
    cmd_t r;
    unique case (pc)
      6'd0:  r = mk(K_MUL,  S_W0, S_X0, S_ZERO, D_T0);
      6'd1:  r = mk(K_MUL,  S_W1, S_X1, S_ZERO, D_T1);
      6'd2:  r = mk(K_ADD,  S_T0, S_T1, S_W2, D_T0);
      6'd3:  r = mk(K_SIGI, S_T0, S_ZERO, S_ZERO, D_T0);
      6'd4:  r = mk(K_SIGR, S_ZERO, S_ZERO, S_ZERO, D_S0);
      6'd5:  r = mk(K_MUL,  S_W3, S_X0, S_ZERO, D_T0);
      6'd6:  r = mk(K_MUL,  S_W4, S_X1, S_ZERO, D_T1);
      6'd7:  r = mk(K_ADD,  S_T0, S_T1, S_W5, D_T0);
      6'd8:  r = mk(K_SIGI, S_T0, S_ZERO, S_ZERO, D_T0);
      6'd9:  r = mk(K_SIGR, S_ZERO, S_ZERO, S_ZERO, D_S1);
      6'd10: r = mk(K_MUL,  S_W6, S_S0, S_ZERO, D_T0);
      6'd11: r = mk(K_MUL,  S_W7, S_S1, S_ZERO, D_T1);
      6'd12: r = mk(K_ADD,  S_T0, S_T1, S_W8, D_T0);
      6'd13: r = mk(K_SIGI, S_T0, S_ZERO, S_ZERO, D_T0);
      6'd14: r = mk(K_SIGR, S_ZERO, S_ZERO, S_ZERO, D_P);
      6'd15: r = mk(K_MUL,  S_P, S_ONEMP, S_ZERO, D_T0);
      6'd16: r = mk(K_MUL,  S_ERR, S_T0, S_ZERO, D_DELTA);
      6'd17: r = mk(K_MUL,  S_DELTA, S_W6, S_ZERO, D_T0);
      6'd18: r = mk(K_MUL,  S_S0, S_ONEMS0, S_ZERO, D_T1);
      6'd19: r = mk(K_MUL,  S_T0, S_T1, S_ZERO, D_HD0);
      6'd20: r = mk(K_MUL,  S_DELTA, S_W7, S_ZERO, D_T0);
      6'd21: r = mk(K_MUL,  S_S1, S_ONEMS1, S_ZERO, D_T1);
      6'd22: r = mk(K_MUL,  S_T0, S_T1, S_ZERO, D_HD1);
      6'd23: r = mk(K_MUL,  S_LR, S_HD0, S_ZERO, D_LD0);
      6'd24: r = mk(K_MUL,  S_LR, S_HD1, S_ZERO, D_LD1);
      6'd25: r = mk(K_MUL,  S_LR, S_DELTA, S_ZERO, D_LDO);
      6'd26: r = mk(K_MUL,  S_LD0, S_X0, S_ZERO, D_T0);
      6'd27: r = mk(K_ADD,  S_W0, S_T0, S_ZERO, D_W0);
      6'd28: r = mk(K_MUL,  S_LD0, S_X1, S_ZERO, D_T0);
      6'd29: r = mk(K_ADD,  S_W1, S_T0, S_ZERO, D_W1);
      6'd30: r = mk(K_ADD,  S_W2, S_LD0, S_ZERO, D_W2);
      6'd31: r = mk(K_MUL,  S_LD1, S_X0, S_ZERO, D_T0);
      6'd32: r = mk(K_ADD,  S_W3, S_T0, S_ZERO, D_W3);
      6'd33: r = mk(K_MUL,  S_LD1, S_X1, S_ZERO, D_T0);
      6'd34: r = mk(K_ADD,  S_W4, S_T0, S_ZERO, D_W4);
      6'd35: r = mk(K_ADD,  S_W5, S_LD1, S_ZERO, D_W5);
      6'd36: r = mk(K_MUL,  S_LDO, S_S0, S_ZERO, D_T0);
      6'd37: r = mk(K_ADD,  S_W6, S_T0, S_ZERO, D_W6);
      6'd38: r = mk(K_MUL,  S_LDO, S_S1, S_ZERO, D_T0);
      6'd39: r = mk(K_ADD,  S_W7, S_T0, S_ZERO, D_W7);
      6'd40: r = mk(K_ADD,  S_W8, S_LDO, S_ZERO, D_W8);
      default: r = mk(K_NOP, S_ZERO, S_ZERO, S_ZERO, D_T0);
    endcase
    return r;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign deliver   = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    op_nxt    = op_r;
    zero_nxt  = zero_r;
    outv_nxt  = out_tvalid_r && !out_tready;
    ctl.cmd      = mk(K_NOP, S_ZERO, S_ZERO, S_ZERO, D_T0);
    ctl.capture  = accept;
    ctl.out_load = deliver;
    ctl.out_zero = zero_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt = op_t'(in_op);
          pc_nxt = '0;
          if (op_t'(in_op) == OP_TRAIN || op_t'(in_op) == OP_PREDICT) begin
            zero_nxt  = 1'b0;
            state_nxt = ST_RUN;
          end else begin
            zero_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        ctl.cmd = prog(pc_r);
        pc_nxt  = pc_r + 6'd1;
        if ((op_r == OP_PREDICT && pc_r == LAST_PRED) || pc_r == LAST_TRAIN)
          state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (deliver) begin
          outv_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= '0;
      op_r         <= OP_NONE;
      zero_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      op_r         <= op_nxt;
      zero_r       <= zero_nxt;
      out_tvalid_r <= outv_nxt;
    end
  end

endmodule

>>> src/mlp_backprop_trainer_2_2_1.sv
// 2-2-1 sigmoid MLP trainer: one item at a time through a shared multiplier.
// After an item is accepted, in_tready stays low through ST_RUN (train and predict only) and
// ST_DONE until the prediction slot is loaded, so no new item is taken before the last is through.
// The microcode sequencer issues one micro-op per cycle through the single
// 32x32 multiply/add unit; ST_DONE waits while a held output is not taken.
// Reset (rst_n low, synchronous): weights cleared, learning rate 0.01, no output.
module mlp_backprop_trainer_2_2_1 import mbt_pkg::*; #(
  parameter int FRAC_BITS           = FRAC_BITS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // operation, first_input, second_input, target, weight_index, weight_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // prediction
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [TGT_W-1:0]      cfg_wdata
);

  dp_ctl_t           ctl;
  logic [PRED_W-1:0] pred;

  // controller: item handshake, microcode sequencing, output slot
  mbt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_op        (in_tdata[1:0]),
    .in_tready    (in_tready),
    .out_tvalid_r (out_tvalid),
    .out_tready   (out_tready),
    .ctl          (ctl)
  );

  // datapath: weights, scratch registers, multiplier, sigmoid table
  mbt_dp #(.FRAC_BITS(FRAC_BITS), .DEPTH(SIGMOID_TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pred_r    (pred)
  );

  assign out_tdata = {{(OUT_DATA_W-PRED_W){1'b0}}, pred};

endmodule

>>> src/mbt_chk.sv
module mbt_chk import mbt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:PRED_W] == '0)
    else $error("pad bits set");

endmodule

bind mlp_backprop_trainer_2_2_1 mbt_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/mlp_backprop_trainer_2_2_1_test.sv
`timescale 1ns / 1ps

module mlp_backprop_trainer_2_2_1_test;
  import mbt_pkg::*;

  localparam int ONE_Q    = 1 << 16;
  localparam int ROM_N    = 1024;
  localparam int IDLE_LIM = 4000;   // cycles with no handshake before giving up

  // Net model: 9 weights, learning rate, sigmoid table, queue of predictions.
  class mlp_scoreboard;
    longint wts[NUM_W];
    longint rate;
    longint sig_tab[ROM_N];
    logic [16:0] pred_q[$];
    int errors;

    function new();
      longint step, term, base, m, s30, sp;
      longint unsigned e;
      step = (longint'(16) << 30) / ROM_N;
      term = longint'(1) << 30;
      base = term;
      e = longint'(1) << 30;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * step) >>> 30) / n;
        base = (n & 1) ? base - term : base + term;
      end
      for (m = 0; m <= ROM_N / 2 + 1; m++) begin
        s30 = (longint'(1) << 60) / ((longint'(1) << 30) + longint'(e));
        sp = (s30 + (longint'(1) << 13)) >>> 14;
        if (ROM_N / 2 + m < ROM_N) sig_tab[ROM_N / 2 + m] = sp;
        if (ROM_N / 2 - m >= 0) sig_tab[ROM_N / 2 - m] = ONE_Q - sp;
        e = (e * longint'(base)) >> 30;
      end
      foreach (wts[i]) wts[i] = 0;
      rate = 655;
      errors = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
    endfunction

    // floor shift of the full product, then clip
    function longint qmul(longint a, longint b);
      return clip32((a * b) >>> 16);
    endfunction

    function longint sig(longint z);
      longint k;
      if (z < -8 * ONE_Q) return sig_tab[0];
      k = (z + 8 * ONE_Q) >>> 10;
      if (k > ROM_N - 1) k = ROM_N - 1;
      return sig_tab[k];
    endfunction

    function longint nsum(int base_i, longint a, longint b);
      return clip32(qmul(wts[base_i], a) + qmul(wts[base_i + 1], b) + wts[base_i + 2]);
    endfunction

    function void set_rate(logic [16:0] v);
      rate = v;
    endfunction

    // accepted input item: update weights, queue the forward prediction
    function void note_item(op_t op, logic signed [31:0] x0, logic signed [31:0] x1,
                            logic [16:0] tgt, logic [3:0] widx, logic signed [31:0] wval);
      longint a, b, s0, s1, p, dl, hd0, hd1, ld0, ld1, ldo;
      a = x0;
      b = x1;
      if (op == OP_LOAD) begin
        if (widx < NUM_W) wts[widx] = wval;
        pred_q.push_back('0);
        return;
      end
      if (op == OP_NONE) begin
        pred_q.push_back('0);
        return;
      end
      s0 = sig(nsum(0, a, b));
      s1 = sig(nsum(3, a, b));
      p = sig(nsum(6, s0, s1));
      pred_q.push_back(p[16:0]);
      if (op == OP_PREDICT) return;
      // hidden deltas see the output weights before the update
      dl  = qmul(longint'(tgt) - p, qmul(p, ONE_Q - p));
      hd0 = qmul(qmul(dl, wts[6]), qmul(s0, ONE_Q - s0));
      hd1 = qmul(qmul(dl, wts[7]), qmul(s1, ONE_Q - s1));
      ld0 = qmul(rate, hd0);
      ld1 = qmul(rate, hd1);
      ldo = qmul(rate, dl);
      wts[0] = clip32(wts[0] + qmul(ld0, a));
      wts[1] = clip32(wts[1] + qmul(ld0, b));
      wts[2] = clip32(wts[2] + ld0);
      wts[3] = clip32(wts[3] + qmul(ld1, a));
      wts[4] = clip32(wts[4] + qmul(ld1, b));
      wts[5] = clip32(wts[5] + ld1);
      wts[6] = clip32(wts[6] + qmul(ldo, s0));
      wts[7] = clip32(wts[7] + qmul(ldo, s1));
      wts[8] = clip32(wts[8] + ldo);
    endfunction

    function void check_pred(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] exp_v;
      if (pred_q.size() == 0) begin
        $display("%0t: unexpected prediction, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp_v = {{(OUT_DATA_W - 17){1'b0}}, pred_q.pop_front()};
      if (got !== exp_v) begin
        $display("%0t: prediction mismatch, expected %h, actual %h", $time, exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // op, first_input, second_input, target, weight_index, weight_value (low bit up)
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // prediction
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [TGT_W-1:0] cfg_wdata = '0;

  mlp_scoreboard sb = new();
  bit no_gaps = 0;       // burst phases: neither side idles
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mlp_backprop_trainer_2_2_1 u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // watchdog: a long stretch without any handshake means the block hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("mlp_backprop_trainer_2_2_1 regression: fail");
      $finish;
    end
  end

  // result side: random stall before each item, then hold ready until taken
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk) out_tready <= 1'b1;
      end else if (!out_tready) begin
        @(negedge clk) out_tready <= 1'b1;
      end
      do @(posedge clk); while (!(out_tvalid && out_tready));
      sb.check_pred(out_tdata);
    end
  end

  // one item: optional gap, present it, wait for the handshake
  task automatic send_item(op_t op, logic [31:0] x0, logic [31:0] x1, logic [16:0] tgt,
                           logic [3:0] widx, logic [31:0] wval);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, wval, widx, tgt, x1, x0, op};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, x0, x1, tgt, widx, wval);
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.pred_q.size() != 0) @(posedge clk);
    repeat (50) @(negedge clk);   // margin longer than the longest item
  endtask

  // only called with the pipe drained
  task automatic write_rate(logic [16:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
    sb.set_rate(v);
  endtask

  // mostly moderate Q16.16 values so the sigmoids stay off the rails
  function automatic logic [31:0] rand_fx();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 32'($urandom_range(0, 6 * ONE_Q) - 3 * ONE_Q);
    if (sel < 8) return 32'($urandom_range(0, 32 * ONE_Q) - 16 * ONE_Q);
    return $urandom();
  endfunction

  function automatic logic [16:0] rand_target();
    return ($urandom_range(0, 9) == 0) ? 17'($urandom()) : 17'($urandom_range(0, ONE_Q));
  endfunction

  task automatic load_all_weights();
    for (int i = 0; i < NUM_W; i++)
      send_item(OP_LOAD, rand_fx(), rand_fx(), rand_target(), 4'(i),
                32'($urandom_range(0, 4 * ONE_Q) - 2 * ONE_Q));
  endtask

  task automatic random_phase(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      if ((i % 100) == 40) no_gaps = 1;
      if ((i % 100) == 60) no_gaps = 0;
      if ((i % 150) == 0) load_all_weights();
      sel = $urandom_range(0, 99);
      if (sel < 50)
        send_item(OP_TRAIN, rand_fx(), rand_fx(), rand_target(), 4'($urandom()), $urandom());
      else if (sel < 72)
        send_item(OP_PREDICT, rand_fx(), rand_fx(), rand_target(), 4'($urandom()), $urandom());
      else if (sel < 95)
        send_item(OP_LOAD, $urandom(), $urandom(), rand_target(),
                  ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8)),
                  rand_fx());
      else
        send_item(OP_NONE, $urandom(), $urandom(), 17'($urandom()), 4'($urandom()), $urandom());
    end
    no_gaps = 0;
  endtask

  initial begin
    logic [16:0] rates[6];
    rates = '{17'd655, 17'd0, 17'h1FFFF, 17'd65536, 17'd6554, 17'd1000};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero weights, every op, loads at the index ends, rail values
    send_item(OP_PREDICT, 32'h0, 32'h0, 17'h0, 4'h0, 32'h0);
    send_item(OP_TRAIN, 32'h0001_0000, 32'hFFFF_0000, 17'h10000, 4'h0, 32'h0);
    for (int i = 0; i < NUM_W; i++)
      send_item(OP_LOAD, 32'h0, 32'h0, 17'h0, 4'(i), 32'(i * 20000 - 80000));
    send_item(OP_TRAIN, 32'h0000_8000, 32'h0001_8000, 17'h10000, 4'h0, 32'h0);
    send_item(OP_TRAIN, 32'hFFFF_4000, 32'h0000_4000, 17'h0, 4'h0, 32'h0);
    send_item(OP_TRAIN, 32'h7FFF_FFFF, 32'h8000_0000, 17'h1FFFF, 4'hF, 32'hFFFF_FFFF);
    send_item(OP_PREDICT, 32'h8000_0000, 32'h7FFF_FFFF, 17'h0, 4'h0, 32'h0);
    send_item(OP_LOAD, 32'h0, 32'h0, 17'h0, 4'd9, 32'h1234_5678);   // index out of range
    send_item(OP_LOAD, 32'h0, 32'h0, 17'h0, 4'd15, 32'h7FFF_FFFF);
    send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF, 4'hF, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 32'h0, 32'h0, 17'h0, 4'd8, 32'h7FFF_FFFF);
    send_item(OP_PREDICT, 32'h0, 32'h0, 17'h0, 4'h0, 32'h0);
    send_item(OP_LOAD, 32'h0, 32'h0, 17'h0, 4'd8, 32'h8000_0000);
    send_item(OP_TRAIN, 32'h0, 32'h0, 17'h10000, 4'h0, 32'h0);
    drain();

    // random phases, one learning rate each; drain doubles as the full pause
    foreach (rates[r]) begin
      write_rate(rates[r]);
      random_phase(295);
      drain();
    end
    write_rate(17'($urandom()));
    random_phase(40);
    drain();

    if (sb.errors == 0 && sb.pred_q.size() == 0)
      $display("mlp_backprop_trainer_2_2_1 regression: pass");
    else
      $display("mlp_backprop_trainer_2_2_1 regression: fail");
    $finish;
  end

endmodule
